// File: sv/f2bs_pkg.sv
`timescale 1ns / 1ps
// Package for the float32 to bfloat16 split block.
// Holds the result struct, constants and the rounding and leading-one helpers; no dependencies.
package f2bs_pkg;

    localparam logic [31:0] ROUND_BIAS   = 32'h0000_7fff;
    localparam logic [30:0] MAX_BF16_MAG = 31'h7f7f_0000;
    localparam logic [7:0]  EXP_ALL_ONES = 8'hff;
    localparam int          HALF_SHIFT   = 16;

    typedef struct packed {
        logic [15:0] high_part;
        logic [15:0] low_part;
        logic        element_finite;
    } t_split_res;

    function automatic logic [15:0] round_bf16(input logic [31:0] bits);
        logic [31:0] sum;
        sum = bits + ROUND_BIAS + {31'd0, bits[HALF_SHIFT]};
        return sum[31:HALF_SHIFT];
    endfunction

    function automatic logic [3:0] lead_one(input logic [15:0] v);
        logic [3:0] p;
        p = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) begin
                p = 4'(i);
            end
        end
        return p;
    endfunction

endpackage

// File: sv/fp32_to_bf16_split_core.sv
`timescale 1ns / 1ps
// Streaming float32 to bfloat16 high/low split with per-row finiteness flag.
// Takes one beat per cycle while not held by back-pressure. Each beat passes an input
// register and then a result register, and its result is presented once it reaches the
// result register. While the output side takes a result every cycle, a new beat is accepted
// every cycle; when both registers are full, o_ready follows i_ready. The row flag
// restarts after a beat with is_last set.
// Depends on f2bs_pkg and f2bs_split.
module fp32_to_bf16_split_core import f2bs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value_bits,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_high_part,
    output logic [15:0] o_low_part,
    output logic        o_element_finite,
    output logic        o_row_finite,
    output logic        o_row_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_produce_low
);
    logic        r_produce_low;
    logic        r_row_all;
    logic        r_s1_v;
    logic [31:0] r_s1_bits;
    logic        r_s1_last;
    logic        r_o_v;
    t_split_res  r_o_res;
    logic        r_o_row;
    logic        r_o_last;
    logic        adv;
    logic        n_row_ok;
    t_split_res  res;

    f2bs_split u_split (
        .i_value_bits  (r_s1_bits),
        .i_produce_low (r_produce_low),
        .o_res         (res)
    );

    assign adv         = !r_o_v || i_ready;
    assign o_ready     = !r_s1_v || adv;
    assign o_cfg_ready = 1'b1;
    assign n_row_ok    = r_row_all & res.element_finite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_produce_low <= 1'b1;
            r_row_all     <= 1'b1;
            r_s1_v        <= 1'b0;
            r_o_v         <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_produce_low <= i_cfg_produce_low;
            end
            if (o_ready) begin
                r_s1_v <= i_valid;
            end
            if (adv) begin
                r_o_v <= r_s1_v;
                if (r_s1_v) begin
                    r_row_all <= r_s1_last ? 1'b1 : n_row_ok;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_bits <= i_value_bits;
            r_s1_last <= i_is_last;
        end
        if (adv && r_s1_v) begin
            r_o_res  <= res;
            r_o_row  <= n_row_ok;
            r_o_last <= r_s1_last;
        end
    end

    assign o_valid          = r_o_v;
    assign o_high_part      = r_o_res.high_part;
    assign o_low_part       = r_o_res.low_part;
    assign o_element_finite = r_o_res.element_finite;
    assign o_row_finite     = r_o_row;
    assign o_row_end        = r_o_last;

`ifndef SYNTH
    a_row_implies_elem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_element_finite) |-> !o_row_finite)
        else $error("row flag set for a non-finite element");
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
    a_row_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s1_v && r_s1_last) |=> r_row_all)
        else $error("row flag not restarted after row end");
`endif

endmodule

// File: sv/f2bs_split.sv
`timescale 1ns / 1ps
// Combinational split of one float32 into bfloat16 high and residual low parts.
// Depends on f2bs_pkg.
module f2bs_split import f2bs_pkg::*; (
    input  logic [31:0] i_value_bits,
    input  logic        i_produce_low,
    output t_split_res  o_res
);
    logic        sgn;
    logic [7:0]  expf;
    logic [7:0]  eff;
    logic [15:0] high;
    logic [31:0] diff;
    logic [16:0] t_val;
    logic [15:0] t_abs;
    logic        r_sgn;
    logic [3:0]  p;
    logic signed [9:0] ex;
    logic [23:0] nmant;
    logic [22:0] smant;
    logic [31:0] rpat;
    logic [15:0] low;

    always_comb begin
        sgn   = i_value_bits[31];
        expf  = i_value_bits[30:23];
        eff   = (expf == 8'd0) ? 8'd1 : expf;
        high  = round_bf16(i_value_bits);
        diff  = {1'b0, i_value_bits[30:0]} - {1'b0, high[14:0], 16'd0};
        t_val = diff[16:0];
        t_abs = t_val[16] ? 16'(-t_val) : t_val[15:0];
        r_sgn = sgn ^ t_val[16];
        p     = lead_one(t_abs);
        ex    = $signed({2'b00, eff}) + $signed({6'd0, p}) - 10'sd23;
        nmant = {8'd0, t_abs} << (5'd23 - {1'b0, p});
        smant = 23'({7'd0, t_abs} << (eff[4:0] - 5'd1));
        if (t_abs == 16'd0) begin
            rpat = 32'd0;
        end else if (ex > 10'sd0) begin
            rpat = {r_sgn, ex[7:0], nmant[22:0]};
        end else begin
            rpat = {r_sgn, 8'd0, smant};
        end
        if (!i_produce_low || expf == EXP_ALL_ONES) begin
            low = 16'd0;
        end else if (high[14:7] == EXP_ALL_ONES) begin
            low = {~sgn, 15'h7f80};
        end else begin
            low = round_bf16(rpat);
        end
        o_res.high_part      = high;
        o_res.low_part       = low;
        o_res.element_finite = (i_value_bits[30:0] <= MAX_BF16_MAG);
    end

endmodule
